/* rtl/core/bbd_pkg.sv */
`timescale 1ns / 1ps

package bbd_pkg;

  localparam int MAX_WIDTH_DEFAULT = 512;

  localparam int SW_W    = 10;
  localparam int SH_W    = 12;
  localparam int NBX_W   = 9;
  localparam int NBY_W   = 11;
  localparam int SUM_W   = 4;
  localparam int TRIPLE_W = 3;
  localparam int GREY_W  = 8;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = 2'd1;

  localparam logic [SW_W-1:0]  SOURCE_WIDTH_RESET  = 10'd24;
  localparam logic [SH_W-1:0]  SOURCE_HEIGHT_RESET = 12'd24;
  localparam logic [NBX_W-1:0] BLOCKS_X_RESET      = 9'd8;
  localparam logic [NBY_W-1:0] BLOCKS_Y_RESET      = 11'd8;

  // floor(x / 3) as (x * RECIP) >> SHIFT, exact over the register ranges.
  localparam logic [10:0] RECIP3_X = 11'd1366;
  localparam int          SHIFT_X  = 12;
  localparam logic [12:0] RECIP3_Y = 13'd5462;
  localparam int          SHIFT_Y  = 14;

  localparam logic [4:0] FULL_BLOCK = 5'd9;

  typedef struct packed {
    logic [GREY_W-1:0] grey_level;
    logic              row_end;
    logic              frame_end;
  } result_t;

  typedef struct packed {
    logic             shift;
    logic [NBX_W-1:0] nbx;
  } cell_ctrl_t;

  function automatic logic [GREY_W-1:0] grey_of(input logic [SUM_W-1:0] sum);
    logic [GREY_W-1:0] g;
    begin
      case (sum)
        4'd0:    g = 8'd255;
        4'd1:    g = 8'd227;
        4'd2:    g = 8'd199;
        4'd3:    g = 8'd170;
        4'd4:    g = 8'd142;
        4'd5:    g = 8'd114;
        4'd6:    g = 8'd85;
        4'd7:    g = 8'd57;
        4'd8:    g = 8'd29;
        default: g = 8'd0;
      endcase
      return g;
    end
  endfunction

endpackage

/* rtl/core/bbd_cell.sv */
`timescale 1ns / 1ps

module bbd_cell
  import bbd_pkg::*;
#(
  parameter int INDEX = 0
) (
  input  logic             clk,
  input  cell_ctrl_t       ctrl,
  input  logic [SUM_W-1:0] neighbor,
  input  logic [SUM_W-1:0] fresh,
  output logic [SUM_W-1:0] value
);

  logic tail;

  assign tail = (int'(ctrl.nbx) == INDEX + 1);

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      value <= tail ? fresh : neighbor;
    end
  end

endmodule

/* rtl/core/bbd_out_buf.sv */
`timescale 1ns / 1ps

module bbd_out_buf
  import bbd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  output logic    full,
  output logic    out_valid,
  output result_t out_data,
  input  logic    out_stall
);

  logic    skid_valid;
  result_t skid_data;
  logic    pop;

  assign pop  = out_valid && !out_stall;
  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (!out_valid) begin
        out_valid <= push;
      end else if (pop) begin
        if (skid_valid) begin
          skid_valid <= 1'b0;
        end else begin
          out_valid <= push;
        end
      end else if (push) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || (pop && !skid_valid)) begin
      out_data <= push_data;
    end else if (pop) begin
      out_data <= skid_data;
    end
    if (out_valid && !pop && push) begin
      skid_data <= push_data;
    end
  end

endmodule

/* rtl/core/bitmap_box_downsample_3x3.sv */
`timescale 1ns / 1ps

// Downsamples a one-bit glyph raster by 3 in each direction with a box filter.
// Pixels enter in raster order on the pixel channel, one word per pixel.
// Each whole 3x3 block yields one grey word, 255 for no ink and 0 for full,
// flagged at the last block of an output row and of the frame. Leftover
// columns and rows are consumed without a result.
// One pixel is taken every cycle while the pixel channel is not stalled. The
// pixel that completes a block, the bottom-right one, pushes its result to the output.
// Partial block sums of the current band move through a chain of cells that
// advances by one block at each block column, so the head cell always holds
// the sum for the block at hand.
// When the receiver stalls, one result waits at the output and a second one
// is held in a skid stage; the pixel channel stalls only while both are full.
// Reset clears the counters and the output, and sets the raster to 24 by 24.
// Sizes are written on the configuration port while the block is idle and
// should change only at a band boundary.

module bitmap_box_downsample_3x3
  import bbd_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  pixel_valid,
  output logic                  pixel_stall,
  input  logic                  pixel_on,
  output logic                  grey_valid,
  input  logic                  grey_stall,
  output logic [GREY_W-1:0]     grey_level,
  output logic                  row_end,
  output logic                  frame_end
);

  localparam int STORE_DEPTH = MAX_WIDTH / 3;
  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int CMPW = (CW >= SW_W) ? CW + 1 : SW_W + 1;
  localparam int BXN  = (MAX_WIDTH - 1) / 3 + 1;
  localparam int BXW  = (BXN > 1) ? $clog2(BXN) : 1;
  localparam int BCW  = ((BXW > NBX_W) ? BXW : NBX_W) + 1;

  logic [SW_W-1:0]  source_width;
  logic [SH_W-1:0]  source_height;
  logic [NBX_W-1:0] nbx;
  logic [NBY_W-1:0] nby;

  logic [CW-1:0]    col;
  logic [1:0]       cx;
  logic [BXW-1:0]   bx;
  logic [SH_W-1:0]  row;
  logic [1:0]       ry;
  logic [NBY_W-1:0] by;
  logic [1:0]       hp;

  logic [SW_W-1:0]  wr_width;
  logic [20:0]      wr_width_prod;
  logic [24:0]      wr_height_prod;

  logic             accept;
  logic             in_range;
  logic [TRIPLE_W-1:0] triple;
  logic [SUM_W-1:0] head;
  logic [4:0]       full_sum;
  logic [SUM_W-1:0] clamped;
  logic [SUM_W-1:0] fresh;
  logic             last_bx;
  logic             push;
  result_t          push_data;
  result_t          out_data;
  cell_ctrl_t       ctrl;

  logic [CMPW-1:0]  col_inc;
  logic [SH_W:0]    row_inc;

  logic [SUM_W-1:0] cell_q [STORE_DEPTH];

  assign wr_width = (CMPW'(cfg_data[SW_W-1:0]) > CMPW'(MAX_WIDTH)) ?
                    SW_W'(MAX_WIDTH) : cfg_data[SW_W-1:0];
  assign wr_width_prod  = 21'(wr_width) * 21'(RECIP3_X);
  assign wr_height_prod = 25'(cfg_data[SH_W-1:0]) * 25'(RECIP3_Y);

  always_ff @(posedge clk) begin
    if (rst) begin
      source_width  <= SOURCE_WIDTH_RESET;
      source_height <= SOURCE_HEIGHT_RESET;
      nbx           <= BLOCKS_X_RESET;
      nby           <= BLOCKS_Y_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SOURCE_WIDTH: begin
          source_width <= wr_width;
          nbx          <= wr_width_prod[SHIFT_X +: NBX_W];
        end
        REG_SOURCE_HEIGHT: begin
          source_height <= cfg_data[SH_W-1:0];
          nby           <= wr_height_prod[SHIFT_Y +: NBY_W];
        end
        default: begin
        end
      endcase
    end
  end

  assign accept   = pixel_valid && !pixel_stall;
  assign in_range = (BCW'(bx) < BCW'(nbx)) && (by < nby);
  assign triple   = TRIPLE_W'(hp) + TRIPLE_W'(pixel_on);
  assign head     = cell_q[0];
  assign full_sum = 5'(head) + 5'(triple);
  assign clamped  = (full_sum > FULL_BLOCK) ? SUM_W'(FULL_BLOCK) : full_sum[SUM_W-1:0];
  assign last_bx  = (BCW'(bx) + BCW'(1)) == BCW'(nbx);

  always_comb begin
    case (ry)
      2'd0:    fresh = SUM_W'(triple);
      2'd1:    fresh = full_sum[SUM_W-1:0];
      default: fresh = head;
    endcase
  end

  assign ctrl.shift = accept && in_range && (cx == 2'd2);
  assign ctrl.nbx   = nbx;

  assign push = ctrl.shift && (ry == 2'd2);
  assign push_data.grey_level = grey_of(clamped);
  assign push_data.row_end    = last_bx;
  assign push_data.frame_end  = last_bx && ((12'(by) + 12'(1)) == 12'(nby));

  genvar i;
  generate
    for (i = 0; i < STORE_DEPTH; i++) begin : g_cell
      if (i == STORE_DEPTH - 1) begin : g_last
        bbd_cell #(.INDEX(i)) u_cell (
          .clk      (clk),
          .ctrl     (ctrl),
          .neighbor (fresh),
          .fresh    (fresh),
          .value    (cell_q[i])
        );
      end else begin : g_mid
        bbd_cell #(.INDEX(i)) u_cell (
          .clk      (clk),
          .ctrl     (ctrl),
          .neighbor (cell_q[i+1]),
          .fresh    (fresh),
          .value    (cell_q[i])
        );
      end
    end
  endgenerate

  assign col_inc = CMPW'(col) + CMPW'(1);
  assign row_inc = (SH_W+1)'(row) + (SH_W+1)'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      cx  <= '0;
      bx  <= '0;
      row <= '0;
      ry  <= '0;
      by  <= '0;
      hp  <= '0;
    end else if (accept) begin
      if (in_range) begin
        if (cx == 2'd0) begin
          hp <= {1'b0, pixel_on};
        end else if (cx == 2'd1) begin
          hp <= triple[1:0];
        end else begin
          hp <= '0;
        end
      end
      if (col_inc >= CMPW'(source_width)) begin
        col <= '0;
        cx  <= '0;
        bx  <= '0;
        hp  <= '0;
        if (row_inc >= (SH_W+1)'(source_height)) begin
          row <= '0;
          ry  <= '0;
          by  <= '0;
        end else begin
          row <= row_inc[SH_W-1:0];
          if (ry == 2'd2) begin
            ry <= '0;
            by <= by + NBY_W'(1);
          end else begin
            ry <= ry + 2'd1;
          end
        end
      end else begin
        col <= col_inc[CW-1:0];
        if (cx == 2'd2) begin
          cx <= '0;
          bx <= bx + BXW'(1);
        end else begin
          cx <= cx + 2'd1;
        end
      end
    end
  end

  bbd_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (pixel_stall),
    .out_valid (grey_valid),
    .out_data  (out_data),
    .out_stall (grey_stall)
  );

  assign grey_level = out_data.grey_level;
  assign row_end    = out_data.row_end;
  assign frame_end  = out_data.frame_end;

endmodule
